@@ rtl/thcp_pkg.sv @@
// shared types, constants and hex decode for the tagged hex coordinate parser
package thcp_pkg;

  localparam int WIN_LEN = 12;
  localparam int TAG_MSG_LEN = 10;
  localparam int NUM_TAGS = 5;
  localparam int COORD_W = 12;
  localparam int CNT_W = 4;
  localparam logic [7:0] CR_BYTE = 8'h0D;

  typedef logic [7:0] byte_t;
  typedef byte_t [WIN_LEN-1:0] window_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_LINK   = 3'd1,
    KIND_HEAD   = 3'd2,
    KIND_TAIL   = 3'd3,
    KIND_BLUE   = 3'd4,
    KIND_ORANGE = 3'd5,
    KIND_YELLOW = 3'd6
  } kind_t;

  typedef struct packed {
    logic                 hit;
    kind_t                kind;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
  } match_t;

  // link notice, oldest byte first, ending in carriage return
  localparam byte_t LINK_TEXT [WIN_LEN] = '{
    8'h57, 8'h49, 8'h46, 8'h49, 8'h20, 8'h47,
    8'h4F, 8'h54, 8'h20, 8'h49, 8'h50, CR_BYTE
  };

  // HED, TAL, BBE, BOE, BYL
  localparam byte_t TAG_TEXT [NUM_TAGS][3] = '{
    '{8'h48, 8'h45, 8'h44},
    '{8'h54, 8'h41, 8'h4C},
    '{8'h42, 8'h42, 8'h45},
    '{8'h42, 8'h4F, 8'h45},
    '{8'h42, 8'h59, 8'h4C}
  };

  localparam kind_t TAG_KIND [NUM_TAGS] = '{
    KIND_HEAD, KIND_TAIL, KIND_BLUE, KIND_ORANGE, KIND_YELLOW
  };

  // non-hex characters decode as zero
  function automatic logic [3:0] hex_value(input byte_t c);
    byte_t d;
    logic [3:0] v;
    d = 8'h00;
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      v = d[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      v = d[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      v = d[3:0];
    end
    return v;
  endfunction

endpackage

@@ rtl/tagged_hex_coordinate_parser.sv @@
// top level: input register, window state and result register of the coordinate parser
//
// Takes one received serial byte per request on the in_ channel (in_tdata = the
// byte, in_tuser = halted) and returns exactly one result per byte on the out_
// channel. out_tuser carries the match kind (0 none, 1 link up, 2..6 head, tail,
// blue, orange, yellow); out_tdata carries coord_x, coord_y and the sticky
// link_up flag. A carriage return closes a message: the newest 12 bytes are
// compared against the link notice, or the newest 10 against a tag plus six
// hex digits. Any match restarts the byte count.
// An accepted byte waits in the input register, then the window compare and hex
// decode feed the result register. One byte is taken every cycle while the
// receiver keeps out_tready high; the window update loop sets that rate.
// Reset (rst_n low, synchronous) empties both stages, clears the byte count
// and the link flag. When the receiver holds out_tready low, the result
// register holds and the input register, if empty, still takes one more
// byte before in_tready falls.
module tagged_hex_coordinate_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] halted
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [11:0] coord_x, [23:12] coord_y, [24] link_up, zero fill
  output logic [2:0]  out_tuser   // [2:0] match_kind
);

  localparam int CNT_W = thcp_pkg::CNT_W;
  localparam int COORD_W = thcp_pkg::COORD_W;

  logic                  in_vld_r;
  thcp_pkg::byte_t       byte_r;
  logic                  halt_r;
  thcp_pkg::window_t     win_r, win_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt, cnt_inc;
  logic                  link_r, link_nxt;
  logic                  out_vld_r;
  thcp_pkg::kind_t       out_kind_r;
  logic [COORD_W-1:0]    out_x_r, out_y_r;
  logic                  out_link_r;
  logic                  adv;
  thcp_pkg::match_t      res;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;

  // shift the new byte in at the top index before matching
  always_comb begin
    win_nxt = {byte_r, win_r[thcp_pkg::WIN_LEN-1:1]};
    cnt_inc = (cnt_r >= CNT_W'(thcp_pkg::WIN_LEN)) ? cnt_r : cnt_r + 1'b1;
  end

  thcp_match u_match (
    .win    (win_nxt),
    .cnt    (cnt_inc),
    .halted (halt_r),
    .res    (res)
  );

  // stale window bytes need no clearing: the count gates every compare
  assign cnt_nxt  = res.hit ? '0 : cnt_inc;
  assign link_nxt = link_r | (res.kind == thcp_pkg::KIND_LINK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
      link_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
      if (adv && in_vld_r) begin
        cnt_r  <= cnt_nxt;
        link_r <= link_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      halt_r <= in_tuser;
    end
    if (adv && in_vld_r) begin
      win_r      <= win_nxt;
      out_kind_r <= res.kind;
      out_x_r    <= res.x;
      out_y_r    <= res.y;
      out_link_r <= link_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'b0, out_link_r, out_y_r, out_x_r};

endmodule

@@ rtl/thcp_match.sv @@
// message recognizer: link notice and tagged coordinate compare on the byte window
module thcp_match (
  input  thcp_pkg::window_t             win,
  input  logic [thcp_pkg::CNT_W-1:0]    cnt,
  input  logic                          halted,
  output thcp_pkg::match_t              res
);

  localparam int CNT_W = thcp_pkg::CNT_W;

  logic link_eq;
  logic [thcp_pkg::NUM_TAGS-1:0] tag_eq;
  logic is_cr;

  assign is_cr = (win[thcp_pkg::WIN_LEN-1] == thcp_pkg::CR_BYTE);

  always_comb begin
    link_eq = 1'b1;
    for (int i = 0; i < thcp_pkg::WIN_LEN; i++) begin
      if (win[i] != thcp_pkg::LINK_TEXT[i]) begin
        link_eq = 1'b0;
      end
    end
  end

  // tag sits at the start of the newest ten bytes
  always_comb begin
    for (int t = 0; t < thcp_pkg::NUM_TAGS; t++) begin
      tag_eq[t] = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (win[thcp_pkg::WIN_LEN - thcp_pkg::TAG_MSG_LEN + k] != thcp_pkg::TAG_TEXT[t][k]) begin
          tag_eq[t] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.hit  = 1'b0;
    res.kind = thcp_pkg::KIND_NONE;
    res.x    = '0;
    res.y    = '0;
    if (is_cr) begin
      if (cnt >= CNT_W'(thcp_pkg::WIN_LEN) && link_eq) begin
        res.hit  = 1'b1;
        res.kind = thcp_pkg::KIND_LINK;
      end else if (!halted && cnt >= CNT_W'(thcp_pkg::TAG_MSG_LEN)) begin
        for (int t = thcp_pkg::NUM_TAGS - 1; t >= 0; t--) begin
          if (tag_eq[t]) begin
            res.hit  = 1'b1;
            res.kind = thcp_pkg::TAG_KIND[t];
          end
        end
        if (res.hit) begin
          res.x = {thcp_pkg::hex_value(win[5]), thcp_pkg::hex_value(win[6]),
                   thcp_pkg::hex_value(win[7])};
          res.y = {thcp_pkg::hex_value(win[8]), thcp_pkg::hex_value(win[9]),
                   thcp_pkg::hex_value(win[10])};
        end
      end
    end
  end

endmodule
